>>> src/ehte_pkg.sv
// Shared types and constants for the event hold timer engine.
`default_nettype none

package ehte_pkg;

    localparam int EVT_W   = 5;
    localparam int LIFE_W  = 8;
    localparam int TYPE_W  = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_INIT_LIFE    = 1'b0;
    localparam logic REG_UNKNOWN_TYPE = 1'b1;

    typedef struct packed {
        logic [5:0]        target_index;
        logic [2:0]        zone_index;
        logic [EVT_W-1:0]  zone_event_bits;
        logic [15:0]       time_delta;
        logic [TYPE_W-1:0] target_type;
        logic              last_zone;
    } item_t;

    typedef struct packed {
        logic [EVT_W-1:0]  held_zone_events;
        logic [EVT_W-1:0]  target_events;
        logic [TYPE_W-1:0] resolved_type;
        logic              target_done;
    } result_t;

    typedef struct packed {
        logic              fire;
        logic              active;
        logic              last;
        logic [EVT_W-1:0]  held;
        logic [TYPE_W-1:0] target_type;
    } merge_ctl_t;

endpackage

`default_nettype wire

>>> src/ehte_lane.sv
// One event lane: updates a single 8-bit life counter and reports whether the event is held.
`default_nettype none

module ehte_lane (
    input  wire logic                      present,
    input  wire logic [ehte_pkg::LIFE_W-1:0] life,
    input  wire logic [15:0]               delta,
    input  wire logic [ehte_pkg::LIFE_W-1:0] init_life,
    output logic      [ehte_pkg::LIFE_W-1:0] life_new,
    output logic                           held
);

    always_comb
    begin
        held = 1'b0;
        if (present)
        begin
            life_new = init_life;
        end
        else if (16'(life) > delta)
        begin
            life_new = life - delta[ehte_pkg::LIFE_W-1:0];
            held     = 1'b1;
        end
        else
        begin
            life_new = '0;
        end
    end

endmodule

`default_nettype wire

>>> src/ehte_merge.sv
// Merging stage: ORs the held zone events per target and resolves the target type.
`default_nettype none

module ehte_merge (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ehte_pkg::merge_ctl_t           ctl,
    input  wire logic [ehte_pkg::TYPE_W-1:0]    unknown_type,
    input  wire logic [ehte_pkg::TYPE_W-1:0]    last_type,
    output ehte_pkg::result_t                   result
);

    logic [ehte_pkg::EVT_W-1:0] acc_reg;
    logic [ehte_pkg::EVT_W-1:0] acc_next;
    logic [ehte_pkg::EVT_W-1:0] acc_all;

    always_comb
    begin
        acc_all  = acc_reg | ctl.held;
        acc_next = acc_reg;
        if (ctl.fire)
        begin
            acc_next = ctl.last ? '0 : acc_all;
        end

        result.held_zone_events = ctl.held;
        result.target_done      = ctl.last;
        result.target_events    = '0;
        result.resolved_type    = '0;
        if (ctl.last)
        begin
            result.target_events = acc_all;
            result.resolved_type = ctl.target_type;
            if (ctl.active && (acc_all != '0) && (ctl.target_type == unknown_type))
            begin
                result.resolved_type = last_type;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

>>> src/event_hold_timer_engine.sv
// Top level of the event hold timer engine: stores, pipeline, lanes and configuration port.
// Usage:
// Zone records enter as words on the item channel (item_valid / item_ready) and one result
// word leaves on the result channel (result_valid / result_ready) for every record, in order.
// The two registers init_life and unknown_type are written over the APB port at byte
// addresses 0 and 4; the user must write them only while the block is idle, which the block
// itself does not enforce. pready is always high. One record per cycle is sustained while
// the receiver does not stall; the per-zone life word is read from the life memory in the
// accept cycle, updated by NUM_EVENTS parallel lanes and written back as the record moves
// from the update stage into the output register, with a bypass for back-to-back records of
// the same zone. After reset the block sweeps the life and last-type memories clear, one
// entry per cycle, over all NUM_TARGETS*NUM_ZONES entries (512 with the default sizes);
// item_ready stays low until the sweep ends, while configuration writes are taken as usual.
// A result word waits in the output register while the receiver stalls; one more record
// can be taken meanwhile and is held in the update stage until the output frees up.
`default_nettype none

module event_hold_timer_engine #(
    parameter int NUM_TARGETS = 64,
    parameter int NUM_ZONES   = 8,
    parameter int NUM_EVENTS  = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire ehte_pkg::item_t                   item,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output ehte_pkg::result_t                      result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ehte_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [ehte_pkg::PDATA_W-1:0]      pwdata,
    output logic      [ehte_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready
);

    localparam int DEPTH  = NUM_TARGETS * NUM_ZONES;
    localparam int LW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW     = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int WORD_W = NUM_EVENTS * ehte_pkg::LIFE_W;
    localparam int EW     = ehte_pkg::EVT_W;
    localparam int LFW    = ehte_pkg::LIFE_W;

    logic [WORD_W-1:0]          life_mem [DEPTH];
    logic [ehte_pkg::TYPE_W-1:0] type_mem [NUM_TARGETS];

    logic [LFW-1:0]              init_life_reg;
    logic [ehte_pkg::TYPE_W-1:0] unknown_type_reg;

    logic          clr_active_reg;
    logic [LW-1:0] clr_cnt_reg;

    logic                        s1_valid_reg;
    ehte_pkg::item_t             s1_item_reg;
    logic [LW-1:0]               s1_addr_reg;
    logic [TW-1:0]               s1_tgt_reg;
    logic [WORD_W-1:0]           life_rd_reg;
    logic [ehte_pkg::TYPE_W-1:0] type_rd_reg;

    logic              result_valid_reg;
    ehte_pkg::result_t result_reg;

    logic              accept;
    logic              s1_fire;
    logic [15:0]       lin_addr;
    logic [15:0]       tgt_ext;
    logic [LW-1:0]     new_addr;
    logic [TW-1:0]     new_tgt;
    logic              tgt_ok;
    logic              zone_ok;
    logic              active;
    logic              life_we;
    logic              type_we;
    logic              fwd_life;
    logic              fwd_type;
    logic [WORD_W-1:0] life_new;
    logic [NUM_EVENTS-1:0] lane_held;
    logic [EW-1:0]     held;
    logic              cfg_write;

    ehte_pkg::merge_ctl_t merge_ctl;
    ehte_pkg::result_t    merge_result;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            ehte_pkg::REG_INIT_LIFE:    prdata = ehte_pkg::PDATA_W'(init_life_reg);
            ehte_pkg::REG_UNKNOWN_TYPE: prdata = ehte_pkg::PDATA_W'(unknown_type_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_life_reg    <= '0;
            unknown_type_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ehte_pkg::REG_INIT_LIFE:    init_life_reg    <= pwdata[LFW-1:0];
                ehte_pkg::REG_UNKNOWN_TYPE: unknown_type_reg <= pwdata[ehte_pkg::TYPE_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Handshake and addressing.
    assign s1_fire    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign accept     = item_valid && item_ready;

    assign tgt_ext  = 16'(item.target_index);
    assign lin_addr = tgt_ext * 16'(NUM_ZONES) + 16'(item.zone_index);
    assign new_addr = lin_addr[LW-1:0];
    assign new_tgt  = tgt_ext[TW-1:0];

    // Update stage.
    assign tgt_ok  = 32'(s1_item_reg.target_index) < 32'(NUM_TARGETS);
    assign zone_ok = 32'(s1_item_reg.zone_index) < 32'(NUM_ZONES);
    assign active  = (init_life_reg != '0) && tgt_ok;
    assign life_we = active && zone_ok;
    assign type_we = active && s1_item_reg.last_zone &&
                     (s1_item_reg.target_type != unknown_type_reg);

    assign fwd_life = s1_fire && life_we && (s1_addr_reg == new_addr);
    assign fwd_type = s1_fire && type_we && (s1_tgt_reg == new_tgt);

    for (genvar j = 0; j < NUM_EVENTS; j++)
    begin : g_lane
        logic present;
        if (j < EW)
        begin : g_bit
            assign present = s1_item_reg.zone_event_bits[j];
        end
        else
        begin : g_nobit
            assign present = 1'b0;
        end

        ehte_lane u_lane (
            .present   (present),
            .life      (life_rd_reg[j*LFW +: LFW]),
            .delta     (s1_item_reg.time_delta),
            .init_life (init_life_reg),
            .life_new  (life_new[j*LFW +: LFW]),
            .held      (lane_held[j])
        );
    end

    for (genvar k = 0; k < EW; k++)
    begin : g_held
        if (k < NUM_EVENTS)
        begin : g_hold
            assign held[k] = s1_item_reg.zone_event_bits[k] || (life_we && lane_held[k]);
        end
        else
        begin : g_pass
            assign held[k] = s1_item_reg.zone_event_bits[k];
        end
    end

    always_comb
    begin
        merge_ctl.fire        = s1_fire;
        merge_ctl.active      = active;
        merge_ctl.last        = s1_item_reg.last_zone;
        merge_ctl.held        = held;
        merge_ctl.target_type = s1_item_reg.target_type;
    end

    ehte_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (merge_ctl),
        .unknown_type (unknown_type_reg),
        .last_type    (type_rd_reg),
        .result       (merge_result)
    );

    // Clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_cnt_reg == LW'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Memories and stage data.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            life_mem[clr_cnt_reg] <= '0;
            if (32'(clr_cnt_reg) < 32'(NUM_TARGETS))
            begin
                type_mem[clr_cnt_reg[TW-1:0]] <= '0;
            end
        end
        else
        begin
            if (s1_fire && life_we)
            begin
                life_mem[s1_addr_reg] <= life_new;
            end
            if (s1_fire && type_we)
            begin
                type_mem[s1_tgt_reg] <= s1_item_reg.target_type;
            end
        end

        if (accept)
        begin
            s1_item_reg <= item;
            s1_addr_reg <= new_addr;
            s1_tgt_reg  <= new_tgt;
            life_rd_reg <= fwd_life ? life_new : life_mem[new_addr];
            type_rd_reg <= fwd_type ? s1_item_reg.target_type : type_mem[new_tgt];
        end

        if (s1_fire)
        begin
            result_reg <= merge_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !item_ready)
        else $error("Item accepted during the memory clearing sweep.");

    a_no_overwrite_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |-> !s1_fire)
        else $error("Update stage advanced into a stalled output register.");

    a_life_write_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && life_we) |-> (init_life_reg != '0))
        else $error("Life memory written while holding is disabled.");

    a_open_target_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.target_done) |->
        (result_reg.target_events == '0 && result_reg.resolved_type == '0))
        else $error("Target summary fields set on a word that does not close a target.");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking regression bench for the event hold timer engine.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_TARGETS = 64;
    localparam int NUM_ZONES   = 8;

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_ready;
    ehte_pkg::item_t               item;
    logic                          result_valid;
    logic                          result_ready;
    ehte_pkg::result_t             result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ehte_pkg::PADDR_W-1:0]  paddr;
    logic [ehte_pkg::PDATA_W-1:0]  pwdata;
    logic [ehte_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    bit [ehte_pkg::LIFE_W-1:0]     life_mem [NUM_TARGETS*NUM_ZONES][ehte_pkg::EVT_W];
    bit [ehte_pkg::TYPE_W-1:0]     last_type_mem [NUM_TARGETS];
    bit [ehte_pkg::EVT_W-1:0]      zone_or;
    bit [ehte_pkg::LIFE_W-1:0]     hold_init;
    bit [ehte_pkg::TYPE_W-1:0]     hold_unknown;

    ehte_pkg::result_t   expected_results [$];
    int                  fail_count;
    int                  records_sent;
    int                  results_checked;
    int                  targets_closed;
    int                  send_idle_pct;
    int                  stall_pct;

    event_hold_timer_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic ehte_pkg::result_t predict_hold(input ehte_pkg::item_t w);
        ehte_pkg::result_t          r;
        logic [ehte_pkg::EVT_W-1:0] held;
        int                         slot;
        int                         j;
        r = '0;
        held = w.zone_event_bits;
        if (hold_init != 0)
        begin
            slot = w.target_index * NUM_ZONES + w.zone_index;
            for (j = 0; j < ehte_pkg::EVT_W; j++)
            begin
                if (w.zone_event_bits[j])
                    life_mem[slot][j] = hold_init;
                else if (life_mem[slot][j] > w.time_delta)
                begin
                    life_mem[slot][j] = life_mem[slot][j] -
                                        w.time_delta[ehte_pkg::LIFE_W-1:0];
                    held[j] = 1'b1;
                end
                else
                    life_mem[slot][j] = '0;
            end
        end
        zone_or = zone_or | held;
        r.held_zone_events = held;
        r.target_done = w.last_zone;
        if (w.last_zone)
        begin
            r.target_events = zone_or;
            r.resolved_type = w.target_type;
            if (hold_init != 0)
            begin
                if (w.target_type != hold_unknown)
                    last_type_mem[w.target_index] = w.target_type;
                else if (zone_or != 0)
                    r.resolved_type = last_type_mem[w.target_index];
            end
            zone_or = '0;
        end
        return r;
    endfunction

    function automatic ehte_pkg::item_t make_word(input int t, input int z, input int ev,
                                                  input int d, input int ty, input bit last);
        ehte_pkg::item_t w;
        w.target_index    = 6'(t);
        w.zone_index      = 3'(z);
        w.zone_event_bits = 5'(ev);
        w.time_delta      = 16'(d);
        w.target_type     = 8'(ty);
        w.last_zone       = last;
        return w;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        ehte_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: result word %h arrived, expected none", $time, result);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("held_zone_events", 8'(want.held_zone_events),
                            8'(result.held_zone_events));
                check_field("target_events", 8'(want.target_events),
                            8'(result.target_events));
                check_field("resolved_type", want.resolved_type, result.resolved_type);
                check_field("target_done", 8'(want.target_done), 8'(result.target_done));
                results_checked++;
                if (want.target_done)
                    targets_closed++;
            end
        end
    end

    task automatic send_word(input ehte_pkg::item_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        expected_results.push_back(predict_hold(w));
        records_sent++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        item_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic reg_index, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= {24'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_index == ehte_pkg::REG_INIT_LIFE)
            hold_init = value;
        else
            hold_unknown = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'b0, value})
        begin
            fail_count++;
            $display("%0t ns: register %0d readback mismatch, expected %h, got %h",
                     $time, reg_index, {24'b0, value}, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_pass_through();
        write_reg(ehte_pkg::REG_INIT_LIFE, 8'd0);
        write_reg(ehte_pkg::REG_UNKNOWN_TYPE, 8'h00);
        send_word(make_word(0, 0, 5'h00, 0, 8'h00, 1'b1));
        send_word(make_word(63, 7, 5'h1F, 65535, 8'hFF, 1'b1));
        send_word(make_word(5, 2, 5'h0A, 17, 8'h21, 1'b0));
        send_word(make_word(5, 3, 5'h15, 0, 8'h00, 1'b1));
        stop_sending();
        wait_idle();
    endtask

    task automatic test_hold_and_decay();
        write_reg(ehte_pkg::REG_INIT_LIFE, 8'd255);
        write_reg(ehte_pkg::REG_UNKNOWN_TYPE, 8'hFF);
        send_word(make_word(1, 0, 5'h1F, 0, 8'h07, 1'b1));
        send_word(make_word(1, 0, 5'h00, 0, 8'hFF, 1'b1));
        send_word(make_word(1, 0, 5'h00, 100, 8'hFF, 1'b1));
        send_word(make_word(1, 0, 5'h00, 155, 8'hFF, 1'b1));
        send_word(make_word(1, 0, 5'h00, 0, 8'hFF, 1'b1));
        send_word(make_word(63, 7, 5'h01, 65535, 8'hFF, 1'b1));
        send_word(make_word(63, 7, 5'h00, 65535, 8'h03, 1'b1));
        send_word(make_word(2, 0, 5'h04, 0, 8'h09, 1'b0));
        send_word(make_word(40, 5, 5'h10, 0, 8'h09, 1'b0));
        send_word(make_word(2, 6, 5'h00, 0, 8'hFF, 1'b1));
        send_word(make_word(2, 0, 5'h00, 1, 8'hFF, 1'b1));
        stop_sending();
        wait_idle();
    endtask

    task automatic test_short_life();
        write_reg(ehte_pkg::REG_INIT_LIFE, 8'd1);
        send_word(make_word(3, 1, 5'h08, 0, 8'h04, 1'b1));
        send_word(make_word(3, 1, 5'h00, 0, 8'hFF, 1'b1));
        send_word(make_word(3, 1, 5'h00, 1, 8'hFF, 1'b1));
        stop_sending();
        wait_idle();
    endtask

    task automatic test_random_pacing(input int count, input int idle_pct, input int stall_rate,
                                      input logic [7:0] life, input logic [7:0] unk);
        logic [5:0]      pool [4];
        ehte_pkg::item_t w;
        int              sent;
        int              z;
        int              last_z;
        logic [7:0]      zmask;
        sent = 0;
        write_reg(ehte_pkg::REG_INIT_LIFE, life);
        write_reg(ehte_pkg::REG_UNKNOWN_TYPE, unk);
        send_idle_pct = idle_pct;
        stall_pct = stall_rate;
        pool[0] = 6'($urandom_range(63));
        pool[1] = 6'($urandom_range(63));
        pool[2] = 6'($urandom_range(63));
        pool[3] = $urandom_range(1) ? 6'd63 : 6'd0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                w = make_word($urandom_range(63), $urandom_range(7), $urandom_range(31),
                              $urandom_range(65535), $urandom_range(255),
                              1'($urandom_range(1)));
                send_word(w);
                sent++;
            end
            else
            begin
                w.target_index = pool[$urandom_range(3)];
                zmask = 8'($urandom_range(255));
                if (zmask == 0)
                    zmask = 8'h01 << $urandom_range(7);
                last_z = 0;
                for (z = 0; z < NUM_ZONES; z++)
                    if (zmask[z])
                        last_z = z;
                for (z = 0; z < NUM_ZONES; z++)
                begin
                    if (zmask[z])
                    begin
                        w.zone_index = 3'(z);
                        w.zone_event_bits = ($urandom_range(3) == 0) ?
                                            5'($urandom_range(31)) : 5'd0;
                        case ($urandom_range(9))
                            0, 1, 2: w.time_delta = 16'd0;
                            8, 9:    w.time_delta = 16'($urandom_range(65535));
                            default: w.time_delta = 16'($urandom_range(40, 1));
                        endcase
                        w.target_type = ($urandom_range(9) < 4) ? unk : 8'($urandom_range(255));
                        w.last_zone = (z == last_z);
                        send_word(w);
                        sent++;
                    end
                end
            end
        end
        stop_sending();
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        #2_000_000;
        $display("event_hold_timer_engine regression: fail");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        zone_or      = '0;
        hold_init    = '0;
        hold_unknown = '0;
        fail_count   = 0;
        records_sent = 0;
        results_checked = 0;
        targets_closed  = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pass_through();
        test_hold_and_decay();
        test_short_life();
        test_random_pacing(200, 0, 0, 8'd255, 8'h00);
        test_random_pacing(200, 63, 0, 8'($urandom_range(60, 2)), 8'($urandom_range(255)));
        test_random_pacing(200, 0, 63, 8'd1, 8'hFF);
        test_random_pacing(200, 8, 8, 8'($urandom_range(255, 1)), 8'($urandom_range(255)));

        $display("Sent %0d zone records and checked %0d results, %0d of them closing a target.",
                 records_sent, results_checked, targets_closed);
        $display("Covered pass-through, hold and decay, short life and four pacing mixes.");
        if (fail_count == 0)
            $display("event_hold_timer_engine regression: pass");
        else
            $display("event_hold_timer_engine regression: fail");
        $finish;
    end

endmodule
